// File: rtl/core/ahfr_pkg.sv
package ahfr_pkg;

   localparam logic [7:0] CHAR_START  = 8'h7E;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_TWO    = 8'h32;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_FOUR   = 8'h34;
   localparam logic [7:0] CHAR_SIX    = 8'h36;
   localparam logic [15:0] SUM_MASK   = 16'hFFFF;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH  = 2'd1;
   localparam logic [1:0] STATUS_HEADER    = 2'd2;
   localparam logic [1:0] STATUS_LENGTH    = 2'd3;

   localparam logic [7:0] MIN_LENGTH_RESET = 8'd16;

   localparam int RECENT_DEPTH = 5;
   localparam int RSP_BITS     = 72;

   typedef logic [7:0] char_type;

   typedef struct packed {
      logic        header_good;
      logic [15:0] running_sum;
      logic [7:0]  address;
      logic [7:0]  code;
      logic [15:0] length;
   } frame_type;

   typedef struct packed {
      logic [15:0] computed_checksum;
      logic [15:0] received_checksum;
      logic [15:0] info_length;
      logic [7:0]  function_code;
      logic [7:0]  device_address;
      logic [1:0]  frame_status;
   } result_type;

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] d;
      d = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         d = c[3:0] + 4'd9;
      end
      return d;
   endfunction

endpackage

// File: rtl/core/ahfr_frame_check.sv
module ahfr_frame_check #(
   parameter int MAX_FRAME_CHARS = 4095,
   parameter int PW = $clog2(MAX_FRAME_CHARS + 1)
) (
   input  ahfr_pkg::frame_type  frame,
   input  ahfr_pkg::char_type   recent [ahfr_pkg::RECENT_DEPTH],
   input  logic [PW-1:0]        position,
   input  logic                 overlong,
   input  logic [7:0]           min_length,
   output ahfr_pkg::result_type result
);

   localparam int CMPW = (PW + 1 > 8) ? PW + 1 : 8;

   logic        dollar;
   logic [7:0]  d0, d1, d2, d3;
   logic [15:0] rx_sum;
   logic [15:0] body;
   logic [15:0] calc;
   logic [CMPW-1:0] count;
   logic        too_short;

   always_comb begin
      dollar = (recent[0] == ahfr_pkg::CHAR_DOLLAR);
      d0 = dollar ? recent[1] : recent[0];
      d1 = dollar ? recent[2] : recent[1];
      d2 = dollar ? recent[3] : recent[2];
      d3 = dollar ? recent[4] : recent[3];
      rx_sum = {ahfr_pkg::hex_value(d3), ahfr_pkg::hex_value(d2),
                ahfr_pkg::hex_value(d1), ahfr_pkg::hex_value(d0)};
      body = frame.running_sum - {8'd0, d0} - {8'd0, d1} - {8'd0, d2} - {8'd0, d3}
             - (dollar ? {8'd0, recent[0]} : 16'd0);
      calc = (body ^ ahfr_pkg::SUM_MASK) + 16'd1;
      count = CMPW'(position) + CMPW'(1);
      too_short = count < CMPW'(min_length);

      result.device_address    = frame.address;
      result.function_code     = frame.code;
      result.info_length       = (frame.code != 8'd0) ? 16'd0 : frame.length;
      result.received_checksum = rx_sum;
      result.computed_checksum = calc;
      if (overlong || too_short) begin
         result.frame_status = ahfr_pkg::STATUS_LENGTH;
      end else if (!frame.header_good || position <= PW'(6)) begin
         result.frame_status = ahfr_pkg::STATUS_HEADER;
      end else if (rx_sum != calc) begin
         result.frame_status = ahfr_pkg::STATUS_MISMATCH;
      end else begin
         result.frame_status = ahfr_pkg::STATUS_OK;
      end
   end

endmodule

// File: rtl/core/ascii_hex_frame_receiver_top.sv
// Channel    Direction  Payload (lowest bit first)
// req_       in         tdata[7:0] rx_byte
// rsp_       out        tdata: status, address, code, length, rx checksum, calc checksum
// csr_       in         data[7:0] min_frame_length
//
// A byte is taken into an input register, checked against the frame state in the
// next cycle and its result, if any, lands in the output register: one byte per
// cycle unless a stalled result holds the pipeline. Reset is synchronous and clears the
// frame state and both stage valids. A stalled result holds the pipeline only when
// the byte waiting behind it also produces a result.
module ascii_hex_frame_receiver_top #(
   parameter int MAX_FRAME_CHARS = 4095
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [1:0] frame_status, [9:2] device_address,
                                    // [17:10] function_code, [33:18] info_length,
                                    // [49:34] received_checksum,
                                    // [65:50] computed_checksum, [71:66] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // [7:0] min_frame_length
);

   localparam int PW = $clog2(MAX_FRAME_CHARS + 1);
   localparam int RD = ahfr_pkg::RECENT_DEPTH;
   localparam int RB = $bits(ahfr_pkg::result_type);

   logic                  s1_valid_ff;
   logic [7:0]            s1_byte_ff;
   logic                  rsp_valid_ff;
   ahfr_pkg::result_type  result_ff;
   logic [7:0]            min_length_ff;

   logic                  in_frame_ff, in_frame_in;
   logic [PW-1:0]         pos_ff, pos_in;
   ahfr_pkg::frame_type   frame_ff, frame_in;
   ahfr_pkg::char_type    recent_ff [RD];
   ahfr_pkg::char_type    recent_in [RD];

   ahfr_pkg::result_type  result_in;
   logic                  s1_emit;
   logic                  s1_advance;
   logic                  out_free;
   logic                  overlong;
   logic                  is_end;
   logic [3:0]            digit;

   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && (!s1_emit || out_free);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(72 - RB)'(0), result_ff};

   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      frame_in    = frame_ff;
      recent_in   = recent_ff;
      s1_emit     = 1'b0;
      overlong    = 1'b0;
      is_end      = (s1_byte_ff == ahfr_pkg::CHAR_CR) || (s1_byte_ff == ahfr_pkg::CHAR_LF);
      digit       = ahfr_pkg::hex_value(s1_byte_ff);
      if (s1_byte_ff == ahfr_pkg::CHAR_START) begin
         in_frame_in = 1'b1;
         pos_in      = '0;
         frame_in    = '0;
         frame_in.header_good = 1'b1;
         for (int i = 0; i < RD; i++) begin
            recent_in[i] = '0;
         end
      end else if (in_frame_ff) begin
         pos_in = pos_ff + PW'(1);
         if (is_end) begin
            s1_emit     = 1'b1;
            in_frame_in = 1'b0;
         end else begin
            frame_in.running_sum = frame_ff.running_sum + {8'd0, s1_byte_ff};
            recent_in[0] = s1_byte_ff;
            for (int i = 1; i < RD; i++) begin
               recent_in[i] = recent_ff[i-1];
            end
            if (pos_in == PW'(1) && s1_byte_ff != ahfr_pkg::CHAR_TWO) begin
               frame_in.header_good = 1'b0;
            end
            if (pos_in == PW'(2) && s1_byte_ff != ahfr_pkg::CHAR_ZERO) begin
               frame_in.header_good = 1'b0;
            end
            if (pos_in == PW'(5) && s1_byte_ff != ahfr_pkg::CHAR_FOUR) begin
               frame_in.header_good = 1'b0;
            end
            if (pos_in == PW'(6) && s1_byte_ff != ahfr_pkg::CHAR_SIX) begin
               frame_in.header_good = 1'b0;
            end
            if (pos_in == PW'(3) || pos_in == PW'(4)) begin
               frame_in.address = {frame_ff.address[3:0], digit};
            end
            if (pos_in == PW'(7) || pos_in == PW'(8)) begin
               frame_in.code = {frame_ff.code[3:0], digit};
            end
            if (pos_in >= PW'(9) && pos_in <= PW'(12)) begin
               frame_in.length = {frame_ff.length[11:0], digit};
            end
            if (pos_in >= PW'(MAX_FRAME_CHARS - 1)) begin
               overlong    = 1'b1;
               s1_emit     = 1'b1;
               in_frame_in = 1'b0;
            end
         end
      end
   end

   ahfr_frame_check #(
      .MAX_FRAME_CHARS(MAX_FRAME_CHARS),
      .PW(PW)
   ) u_check (
      .frame(frame_in),
      .recent(recent_in),
      .position(pos_in),
      .overlong(overlong),
      .min_length(min_length_ff),
      .result(result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         in_frame_ff   <= 1'b0;
         pos_ff        <= '0;
         frame_ff      <= '0;
         min_length_ff <= ahfr_pkg::MIN_LENGTH_RESET;
         for (int i = 0; i < RD; i++) begin
            recent_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            min_length_ff <= csr_data;
         end
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s1_advance) begin
            in_frame_ff <= in_frame_in;
            pos_ff      <= pos_in;
            frame_ff    <= frame_in;
            recent_ff   <= recent_in;
         end
         if (s1_advance && s1_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
      end
      if (s1_advance && s1_emit) begin
         result_ff <= result_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(s1_advance && s1_emit && rsp_valid_ff && !rsp_tready))
      else $error("result register overwritten while stalled");

   a_frame_closes: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_emit |=> !in_frame_ff && rsp_valid_ff)
      else $error("frame still open after its result");

   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> pos_ff < PW'(MAX_FRAME_CHARS - 1))
      else $error("character position beyond frame limit");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_byte_ff))
      else $error("held byte lost from input stage");

endmodule

// File: tb/frame_scoreboard_pkg.sv
package frame_scoreboard_pkg;

   import ahfr_pkg::*;

   class frame_scoreboard;

      int unsigned frame_limit;
      logic [7:0]  min_length;
      bit          in_frame;
      int unsigned position;
      logic [15:0] body_sum;
      char_type    recent[RECENT_DEPTH];
      bit          header_ok;
      logic [7:0]  address;
      logic [7:0]  code;
      logic [15:0] length;
      result_type  expected_frames[$];
      int unsigned frames_predicted;
      int unsigned mismatches;

      function new(int unsigned limit);
         int i;
         frame_limit = limit;
         min_length = MIN_LENGTH_RESET;
         in_frame = 1'b0;
         position = 0;
         body_sum = '0;
         for (i = 0; i < RECENT_DEPTH; i++) begin
            recent[i] = '0;
         end
         header_ok = 1'b0;
         address = '0;
         code = '0;
         length = '0;
         frames_predicted = 0;
         mismatches = 0;
      endfunction

      function void set_min_length(logic [7:0] value);
         min_length = value;
      endfunction

      function int unsigned pending();
         return expected_frames.size();
      endfunction

      function logic [3:0] digit_of(char_type c);
         if (c >= "0" && c <= "9") begin
            return 4'(c - "0");
         end else if (c >= "A" && c <= "F") begin
            return 4'(c - "A" + 10);
         end else if (c >= "a" && c <= "f") begin
            return 4'(c - "a" + 10);
         end
         return 4'd0;
      endfunction

      function void close_frame(bit overlong);
         int unsigned tail;
         int          i;
         char_type    c;
         logic [15:0] rx;
         logic [15:0] body;
         result_type  r;
         tail = (recent[0] == CHAR_DOLLAR) ? 1 : 0;
         rx = '0;
         body = body_sum;
         for (i = 0; i < 4; i++) begin
            c = recent[tail + 3 - i];
            rx = {rx[11:0], digit_of(c)};
            body = body - 16'(c);
         end
         if (tail != 0) begin
            body = body - 16'(recent[0]);
         end
         r.computed_checksum = (body ^ SUM_MASK) + 16'd1;
         r.received_checksum = rx;
         r.info_length = (code != 8'd0) ? 16'd0 : length;
         r.function_code = code;
         r.device_address = address;
         if (overlong || position + 1 < min_length) begin
            r.frame_status = STATUS_LENGTH;
         end else if (!header_ok || position <= 6) begin
            r.frame_status = STATUS_HEADER;
         end else if (rx != r.computed_checksum) begin
            r.frame_status = STATUS_MISMATCH;
         end else begin
            r.frame_status = STATUS_OK;
         end
         expected_frames.push_back(r);
         frames_predicted++;
         in_frame = 1'b0;
      endfunction

      function void note_byte(char_type c);
         int         i;
         logic [3:0] d;
         if (c == CHAR_START) begin
            in_frame = 1'b1;
            position = 0;
            body_sum = '0;
            for (i = 0; i < RECENT_DEPTH; i++) begin
               recent[i] = '0;
            end
            header_ok = 1'b1;
            address = '0;
            code = '0;
            length = '0;
            return;
         end
         if (!in_frame) begin
            return;
         end
         position++;
         if (c == CHAR_CR || c == CHAR_LF) begin
            close_frame(1'b0);
            return;
         end
         body_sum = body_sum + 16'(c);
         for (i = RECENT_DEPTH - 1; i > 0; i--) begin
            recent[i] = recent[i - 1];
         end
         recent[0] = c;
         d = digit_of(c);
         case (position)
            1: if (c != CHAR_TWO) header_ok = 1'b0;
            2: if (c != CHAR_ZERO) header_ok = 1'b0;
            5: if (c != CHAR_FOUR) header_ok = 1'b0;
            6: if (c != CHAR_SIX) header_ok = 1'b0;
            3, 4: address = {address[3:0], d};
            7, 8: code = {code[3:0], d};
            9, 10, 11, 12: length = {length[11:0], d};
            default: ;
         endcase
         if (position + 2 > frame_limit) begin
            close_frame(1'b1);
         end
      endfunction

      task report(string msg);
         $display("frame mismatch: %s", msg);
         mismatches++;
      endtask

      task check_result(logic [RSP_BITS-1:0] beat);
         result_type got;
         result_type want;
         got = result_type'(beat[$bits(result_type)-1:0]);
         if (expected_frames.size() == 0) begin
            report($sformatf("result beat %h with no frame pending", beat));
            return;
         end
         want = expected_frames.pop_front();
         if (got.frame_status !== want.frame_status) begin
            report($sformatf("frame_status got %0d want %0d",
                             got.frame_status, want.frame_status));
         end
         if (got.device_address !== want.device_address) begin
            report($sformatf("device_address got %h want %h",
                             got.device_address, want.device_address));
         end
         if (got.function_code !== want.function_code) begin
            report($sformatf("function_code got %h want %h",
                             got.function_code, want.function_code));
         end
         if (got.info_length !== want.info_length) begin
            report($sformatf("info_length got %h want %h",
                             got.info_length, want.info_length));
         end
         if (got.received_checksum !== want.received_checksum) begin
            report($sformatf("received_checksum got %h want %h",
                             got.received_checksum, want.received_checksum));
         end
         if (got.computed_checksum !== want.computed_checksum) begin
            report($sformatf("computed_checksum got %h want %h",
                             got.computed_checksum, want.computed_checksum));
         end
         if (beat[RSP_BITS-1:$bits(result_type)] !== '0) begin
            report($sformatf("padding bits not zero in beat %h", beat));
         end
      endtask

   endclass

endpackage

// File: tb/testbench.sv
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import ahfr_pkg::*;
   import frame_scoreboard_pkg::*;

   localparam int FRAME_LIMIT = 4095;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 4;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [7:0]          csr_data = '0;

   frame_scoreboard frames;
   char_type        pending_bytes[$];
   int              send_idle = 0;
   int              recv_idle = 0;
   int              hold_left = 0;
   int              hold_requests = 0;
   int              hold_served = 0;
   int              bytes_sent = 0;
   int              cycle_count = 0;

   ascii_hex_frame_receiver_top #(
      .MAX_FRAME_CHARS(FRAME_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ascii_hex_frame_receiver_top regression: fail");
         $finish;
      end
   end

   // A long hold-off is counted down here while the sender keeps offering bytes.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_requests != hold_served) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_served <= hold_requests;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            frames.check_result(rsp_tdata);
         end
         if (req_tvalid && req_tready) begin
            frames.note_byte(req_tdata);
         end
         if (csr_valid && csr_ready) begin
            frames.set_min_length(csr_data);
         end
      end
   end

   task send_byte(input char_type c);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         send_byte(s[i]);
      end
   endtask

   task send_pending();
      while (pending_bytes.size() != 0) begin
         send_byte(pending_bytes.pop_front());
      end
   endtask

   task drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (frames.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_min_length(input logic [7:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function void push_hex(input logic [15:0] value, input int digits, input bit lower);
      int         k;
      logic [3:0] nib;
      for (k = digits - 1; k >= 0; k--) begin
         nib = value[4*k +: 4];
         if (nib < 10) begin
            pending_bytes.push_back(8'("0" + nib));
         end else begin
            pending_bytes.push_back(8'((lower ? "a" : "A") + nib - 10));
         end
      end
   endfunction

   function void make_frame(input logic [7:0] addr, input logic [7:0] code,
                            input logic [15:0] len, input int info_chars,
                            input bit header_ok, input bit sum_ok, input bit dollar,
                            input char_type end_mark, input bit lower);
      char_type    hdr[4];
      int          first;
      int          k;
      logic [15:0] total;
      hdr[0] = CHAR_TWO;
      hdr[1] = CHAR_ZERO;
      hdr[2] = CHAR_FOUR;
      hdr[3] = CHAR_SIX;
      if (!header_ok) begin
         k = $urandom_range(3);
         hdr[k] = hdr[k] + 8'($urandom_range(1, 9));
      end
      pending_bytes.push_back(CHAR_START);
      first = pending_bytes.size();
      pending_bytes.push_back(hdr[0]);
      pending_bytes.push_back(hdr[1]);
      push_hex(16'(addr), 2, lower);
      pending_bytes.push_back(hdr[2]);
      pending_bytes.push_back(hdr[3]);
      push_hex(16'(code), 2, lower);
      push_hex(len, 4, lower);
      repeat (info_chars) pending_bytes.push_back(8'($urandom_range(8'h20, 8'h7D)));
      total = '0;
      for (k = first; k < pending_bytes.size(); k++) begin
         total = total + 16'(pending_bytes[k]);
      end
      total = (total ^ SUM_MASK) + 16'd1;
      if (!sum_ok) begin
         total = total ^ 16'($urandom_range(1, 16'hFFFF));
      end
      push_hex(total, 4, lower);
      if (dollar) begin
         pending_bytes.push_back(CHAR_DOLLAR);
      end
      pending_bytes.push_back(end_mark);
   endfunction

   task random_frame();
      int       kind;
      int       cut;
      char_type b;
      kind = $urandom_range(99);
      if (kind < 85) begin
         make_frame(8'($urandom_range(255)),
                    $urandom_range(1) ? 8'h00 : 8'($urandom_range(255)),
                    16'($urandom_range(16'hFFFF)), $urandom_range(6),
                    $urandom_range(19) != 0, $urandom_range(4) != 0,
                    $urandom_range(2) == 0,
                    $urandom_range(1) ? CHAR_CR : CHAR_LF, $urandom_range(1));
         if (kind >= 75) begin
            cut = $urandom_range(1, pending_bytes.size() - 1);
            repeat (cut) void'(pending_bytes.pop_back());
            if ($urandom_range(1)) begin
               pending_bytes.push_back(CHAR_CR);
            end
         end else if ($urandom_range(3) == 0) begin
            pending_bytes.push_back(CHAR_LF);
         end
      end else if (kind < 95) begin
         repeat ($urandom_range(1, 8)) pending_bytes.push_back(8'($urandom_range(255)));
      end else begin
         pending_bytes.push_back(CHAR_START);
         repeat ($urandom_range(20)) begin
            do b = 8'($urandom_range(255));
            while (b == CHAR_START || b == CHAR_CR || b == CHAR_LF);
            pending_bytes.push_back(b);
         end
         pending_bytes.push_back(CHAR_CR);
      end
      send_pending();
   endtask

   task run_random(input int byte_quota, input int result_quota);
      int first_bytes;
      int first_results;
      first_bytes = bytes_sent;
      first_results = frames.frames_predicted;
      while (bytes_sent - first_bytes < byte_quota ||
             frames.frames_predicted - first_results < result_quota) begin
         random_frame();
      end
   endtask

   initial begin
      frames = new(FRAME_LIMIT);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle = 23;
      recv_idle = 65;

      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
      make_frame(8'h00, 8'h00, 16'h0000, 0, 1'b1, 1'b1, 1'b0, CHAR_CR, 1'b0);
      make_frame(8'hFF, 8'h00, 16'hFFFF, 2, 1'b1, 1'b1, 1'b1, CHAR_LF, 1'b1);
      pending_bytes.push_back(CHAR_LF);
      make_frame(8'h5A, 8'hE2, 16'h1234, 1, 1'b1, 1'b1, 1'b0, CHAR_CR, 1'b0);
      make_frame(8'h3C, 8'h00, 16'h0042, 3, 1'b1, 1'b0, 1'b0, CHAR_CR, 1'b1);
      make_frame(8'h01, 8'h00, 16'h0010, 0, 1'b0, 1'b1, 1'b0, CHAR_LF, 1'b0);
      send_pending();
      send_text("~20Gz46xy00q0FFFF\r");
      send_text("~2046");
      make_frame(8'hA7, 8'h00, 16'h00C3, 0, 1'b1, 1'b1, 1'b0, CHAR_CR, 1'b0);
      send_pending();
      send_text("~2046\r");
      send_byte(CHAR_START);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CHAR_CR);

      write_min_length(8'd0);
      send_text("~\r");
      send_text("~$\r");
      send_text("~20\r");
      send_text("~204\n");

      write_min_length(8'd255);
      make_frame(8'h12, 8'h00, 16'h0001, 0, 1'b1, 1'b1, 1'b0, CHAR_CR, 1'b0);
      send_pending();

      // An 18-character frame sits exactly on the limit of 18 and below a limit of 19.
      write_min_length(8'd18);
      make_frame(8'h34, 8'h00, 16'h0002, 0, 1'b1, 1'b1, 1'b0, CHAR_CR, 1'b0);
      send_pending();
      write_min_length(8'd19);
      make_frame(8'h34, 8'h00, 16'h0002, 0, 1'b1, 1'b1, 1'b0, CHAR_CR, 1'b0);
      send_pending();

      write_min_length(8'd16);
      run_random(70, 3);

      write_min_length(8'($urandom_range(0, 40)));
      send_idle = 65;
      recv_idle = 23;
      hold_requests = hold_requests + 1;
      run_random(70, 3);

      write_min_length(8'($urandom_range(10, 24)));
      send_idle = 0;
      recv_idle = 0;
      run_random(70, 3);

      drain_results();
      if (frames.mismatches == 0) begin
         $display("ascii_hex_frame_receiver_top regression: pass");
      end else begin
         $display("ascii_hex_frame_receiver_top regression: fail");
      end
      $finish;
   end

endmodule
